>>> rtl/core/particle_floor_and_cylinder_collide_core_macros.svh
// Assertion macros shared by the collision core.
`ifndef PARTICLE_FLOOR_AND_CYLINDER_COLLIDE_CORE_MACROS_SVH
`define PARTICLE_FLOOR_AND_CYLINDER_COLLIDE_CORE_MACROS_SVH

// Check on every edge outside reset.
`define PCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define PCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/pcc_pkg.sv
// Types and constants of the particle collision core.
package pcc_pkg;

  localparam int FRAC_BITS = 16;
  // Push only when dist * 10000 > 2^FRAC_BITS.
  localparam logic [30:0] AXIS_THR = 31'((64'd1 << FRAC_BITS) / 10000);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;

  localparam logic [1:0] REG_PLAYER_X = 2'd0;
  localparam logic [1:0] REG_PLAYER_Z = 2'd1;
  localparam logic [1:0] REG_PUSH_RADIUS = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vy;
    logic last;
    logic sx;
    logic sz;
  } item_t;

  typedef struct packed {
    item_t item;
    logic [30:0] adx;
    logic [30:0] adz;
    logic in_cyl;
  } pass_t;

  typedef struct packed {
    item_t item;
    logic push;
  } post_t;

endpackage

>>> rtl/core/pcc_front.sv
// Floor bounce, player offsets, squares and the inside test (three stages).
module pcc_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_i,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_y,
  input  logic last_in,
  input  logic signed [31:0] player_x,
  input  logic signed [31:0] player_z,
  input  logic [30:0] radius,
  output logic valid_o,
  output logic [62:0] dsq_o,
  output pcc_pkg::pass_t side_o
);
  import pcc_pkg::*;

  logic signed [32:0] dx, dz, vneg, vhalf;
  logic [32:0] adx_w, adz_w;
  logic near_w;
  item_t item_w;

  item_t item1, item2;
  logic [30:0] adx1, adz1, adx2, adz2;
  logic near1, near2, v1, v2;
  logic [61:0] sqx, sqz, rsq;

  always_comb begin
    dx = {pos_x[31], pos_x} - {player_x[31], player_x};
    dz = {pos_z[31], pos_z} - {player_z[31], player_z};
    adx_w = dx[32] ? 33'(-dx) : 33'(dx);
    adz_w = dz[32] ? 33'(-dz) : 33'(dz);
    near_w = (adx_w <= {2'b00, radius}) && (adz_w <= {2'b00, radius});
    vneg = -{vel_y[31], vel_y};
    // halve toward zero
    vhalf = vneg[32] ? ((vneg + 33'sd1) >>> 1) : (vneg >>> 1);
    item_w.x = pos_x;
    item_w.z = pos_z;
    item_w.last = last_in;
    item_w.sx = dx[32];
    item_w.sz = dz[32];
    if (pos_y[31]) begin
      item_w.y = '0;
      item_w.vy = vhalf[31:0];
    end else begin
      item_w.y = pos_y;
      item_w.vy = vel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1 <= valid_i;
      v2 <= v1;
      valid_o <= v2;
    end
    if (en) begin
      item1 <= item_w;
      adx1 <= adx_w[30:0];
      adz1 <= adz_w[30:0];
      near1 <= near_w;
      item2 <= item1;
      adx2 <= adx1;
      adz2 <= adz1;
      near2 <= near1;
      sqx <= adx1 * adx1;
      sqz <= adz1 * adz1;
      rsq <= radius * radius;
      dsq_o <= {1'b0, sqx} + {1'b0, sqz};
      side_o.item <= item2;
      side_o.adx <= adx2;
      side_o.adz <= adz2;
      side_o.in_cyl <= near2 && (({1'b0, sqx} + {1'b0, sqz}) < {1'b0, rsq});
    end
  end

endmodule

>>> rtl/core/pcc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pcc_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_i,
  input  logic [62:0] dsq_i,
  input  pcc_pkg::pass_t side_i,
  output logic valid_o,
  output logic [30:0] dist_o,
  output pcc_pkg::pass_t side_o
);
  import pcc_pkg::*;

  logic v [0:SQRT_STEPS];
  logic [63:0] rem [0:SQRT_STEPS];
  logic [63:0] res [0:SQRT_STEPS];
  pass_t side [0:SQRT_STEPS];

  assign v[0] = valid_i;
  assign rem[0] = {1'b0, dsq_i};
  assign res[0] = '0;
  assign side[0] = side_i;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;
    assign trial = res[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        side[s+1] <= side[s];
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          res[s+1] <= (res[s] >> 1) + BIT;
        end else begin
          rem[s+1] <= rem[s];
          res[s+1] <= res[s] >> 1;
        end
      end
    end
  end

  assign valid_o = v[SQRT_STEPS];
  assign dist_o = res[SQRT_STEPS][30:0];
  assign side_o = side[SQRT_STEPS];

endmodule

>>> rtl/core/pcc_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one bit per stage.
module pcc_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_i,
  input  logic [61:0] num_x,
  input  logic [61:0] num_z,
  input  logic [30:0] den,
  input  pcc_pkg::post_t side_i,
  output logic valid_o,
  output logic [30:0] quo_x,
  output logic [30:0] quo_z,
  output pcc_pkg::post_t side_o
);
  import pcc_pkg::*;

  logic v [0:DIV_STEPS];
  logic [31:0] rx [0:DIV_STEPS];
  logic [31:0] rz [0:DIV_STEPS];
  // low dividend bits shift out at the top while quotient bits enter below
  logic [30:0] qx [0:DIV_STEPS];
  logic [30:0] qz [0:DIV_STEPS];
  logic [30:0] d [0:DIV_STEPS];
  post_t side [0:DIV_STEPS];

  assign v[0] = valid_i;
  assign rx[0] = {1'b0, num_x[61:31]};
  assign rz[0] = {1'b0, num_z[61:31]};
  assign qx[0] = num_x[30:0];
  assign qz[0] = num_z[30:0];
  assign d[0] = den;
  assign side[0] = side_i;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [31:0] tx, tz;
    assign tx = {rx[s][30:0], qx[s][30]};
    assign tz = {rz[s][30:0], qz[s][30]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        side[s+1] <= side[s];
        d[s+1] <= d[s];
        if (tx >= {1'b0, d[s]}) begin
          rx[s+1] <= tx - {1'b0, d[s]};
          qx[s+1] <= {qx[s][29:0], 1'b1};
        end else begin
          rx[s+1] <= tx;
          qx[s+1] <= {qx[s][29:0], 1'b0};
        end
        if (tz >= {1'b0, d[s]}) begin
          rz[s+1] <= tz - {1'b0, d[s]};
          qz[s+1] <= {qz[s][29:0], 1'b1};
        end else begin
          rz[s+1] <= tz;
          qz[s+1] <= {qz[s][29:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v[DIV_STEPS];
  assign quo_x = qx[DIV_STEPS];
  assign quo_z = qz[DIV_STEPS];
  assign side_o = side[DIV_STEPS];

endmodule

>>> rtl/core/particle_floor_and_cylinder_collide_core.sv
// Particle floor and cylinder collision core, top level.
// Usage:
//   Input channel in_valid/in_ready carries one particle word (pos_x, pos_y,
//   pos_z, vel_y, last_in); output channel out_valid/out_ready returns the
//   corrected word (new_x, new_y, new_z, new_vy, last_out), one per input,
//   in order. All values are signed Q16.16.
//   Configuration: cfg_we with cfg_index 0/1/2 writes player_x, player_z and
//   push_radius (low 31 bits); index 3 is ignored. Write only while idle.
// Pipeline:
//   3 front stages, 32 square-root stages (one root bit each), 1 multiply
//   stage, 31 divider stages (one quotient bit each) and the output register.
//   One word per cycle while in_ready is high.
// Stall and reset:
//   A stalled receiver holds the output word; the next word lands in a skid
//   register, and only once that is full does the whole pipeline and in_ready
//   stop. Nothing is dropped or repeated. Synchronous reset empties the
//   pipeline and sets all three registers to zero.
module particle_floor_and_cylinder_collide_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_y,
  input  logic last_in,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_z,
  output logic signed [31:0] new_vy,
  output logic last_out
);
  import pcc_pkg::*;
  `include "particle_floor_and_cylinder_collide_core_macros.svh"

  logic signed [31:0] player_x, player_z;
  logic [30:0] push_radius;
  logic en, skid_full;

  logic fr_valid, sq_valid, dv_valid, mu_valid;
  logic [62:0] fr_dsq;
  pass_t fr_side, sq_side;
  logic [30:0] sq_dist, mu_dist, qx, qz;
  logic [61:0] mu_nx, mu_nz;
  post_t mu_side, dv_side;

  logic [30:0] gap;
  logic signed [33:0] sum_x, sum_z;
  logic signed [31:0] fx, fz;
  logic signed [31:0] skid_x, skid_y, skid_z, skid_vy;
  logic skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_z <= '0;
      push_radius <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYER_X: player_x <= cfg_data;
        REG_PLAYER_Z: player_z <= cfg_data;
        REG_PUSH_RADIUS: push_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign en = !skid_full;
  assign in_ready = en;

  pcc_front u_front (
    .clk(clk), .rst(rst), .en(en), .valid_i(in_valid),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .vel_y(vel_y), .last_in(last_in),
    .player_x(player_x), .player_z(player_z), .radius(push_radius),
    .valid_o(fr_valid), .dsq_o(fr_dsq), .side_o(fr_side)
  );

  pcc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .valid_i(fr_valid), .dsq_i(fr_dsq),
    .side_i(fr_side), .valid_o(sq_valid), .dist_o(sq_dist), .side_o(sq_side)
  );

  // scale the offsets by the gap to the wall
  assign gap = push_radius - sq_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (en) begin
      mu_valid <= sq_valid;
    end
    if (en) begin
      mu_nx <= sq_side.adx * gap;
      mu_nz <= sq_side.adz * gap;
      mu_dist <= sq_dist;
      mu_side.item <= sq_side.item;
      mu_side.push <= sq_side.in_cyl && (sq_dist > AXIS_THR);
    end
  end

  pcc_div u_div (
    .clk(clk), .rst(rst), .en(en), .valid_i(mu_valid),
    .num_x(mu_nx), .num_z(mu_nz), .den(mu_dist), .side_i(mu_side),
    .valid_o(dv_valid), .quo_x(qx), .quo_z(qz), .side_o(dv_side)
  );

  always_comb begin
    sum_x = {{2{dv_side.item.x[31]}}, dv_side.item.x}
          + (dv_side.item.sx ? -{3'b000, qx} : {3'b000, qx});
    sum_z = {{2{dv_side.item.z[31]}}, dv_side.item.z}
          + (dv_side.item.sz ? -{3'b000, qz} : {3'b000, qz});
    if (!dv_side.push) begin
      fx = dv_side.item.x;
    end else if (sum_x > 34'sh0_7FFF_FFFF) begin
      fx = 32'sh7FFF_FFFF;
    end else if (sum_x < -34'sh0_8000_0000) begin
      fx = 32'sh8000_0000;
    end else begin
      fx = sum_x[31:0];
    end
    if (!dv_side.push) begin
      fz = dv_side.item.z;
    end else if (sum_z > 34'sh0_7FFF_FFFF) begin
      fz = 32'sh7FFF_FFFF;
    end else if (sum_z < -34'sh0_8000_0000) begin
      fz = 32'sh8000_0000;
    end else begin
      fz = sum_z[31:0];
    end
  end

  // output register with a skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (en) begin
      if (!out_valid || out_ready) begin
        out_valid <= dv_valid;
      end else if (dv_valid) begin
        skid_full <= 1'b1;
      end
    end else if (out_ready) begin
      skid_full <= 1'b0;
    end
    if (en) begin
      if (!out_valid || out_ready) begin
        new_x <= fx;
        new_y <= dv_side.item.y;
        new_z <= fz;
        new_vy <= dv_side.item.vy;
        last_out <= dv_side.item.last;
      end else begin
        skid_x <= fx;
        skid_y <= dv_side.item.y;
        skid_z <= fz;
        skid_vy <= dv_side.item.vy;
        skid_last <= dv_side.item.last;
      end
    end else if (out_ready) begin
      new_x <= skid_x;
      new_y <= skid_y;
      new_z <= skid_z;
      new_vy <= skid_vy;
      last_out <= skid_last;
    end
  end

  `PCC_ASSERT(a_skid_behind_out, skid_full |-> out_valid, "skid word without output word")
  `PCC_ASSERT(a_skid_on_stall, $rose(skid_full) |-> $past(out_valid && !out_ready), "skid filled without stall")
  `PCC_ASSERT(a_height_floor, out_valid |-> !new_y[31], "negative height delivered")
  `PCC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !skid_full, "pipeline not empty after reset")

endmodule

>>> bench/tb.sv
// Testbench for the particle floor and cylinder collision core.
`timescale 1ns / 1ps

module tb;
  import pcc_pkg::*;

  localparam int LATENCY = 68;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vy;
    logic last;
  } particle_t;

  // One row of the directed table; has_exp marks a hand-typed expectation.
  typedef struct {
    particle_t stim;
    bit has_exp;
    particle_t exp;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, vel_y = '0;
  logic last_in = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] new_x, new_y, new_z, new_vy;
  logic last_out;

  logic signed [31:0] centre_x = 0, centre_z = 0;
  logic [30:0] radius = 0;

  particle_t corrected_q[$];
  int errors = 0;
  int words_in = 0, words_out = 0, pushed_cnt = 0, bounce_cnt = 0;
  int idle_cycles = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  always #2 clk = ~clk;

  particle_floor_and_cylinder_collide_core i_dut (.*);

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic particle_t collide(particle_t p);
    particle_t r;
    longint px, pz, vy, dx, dz, rad, d, gap;
    longint unsigned ux, uz, dsq;
    r = p;
    px = p.x;
    pz = p.z;
    vy = p.vy;
    rad = longint'(radius);
    if (p.y < 0) begin
      r.y = 0;
      r.vy = 32'(-vy / 2);
      bounce_cnt++;
    end
    dx = px - centre_x;
    dz = pz - centre_z;
    ux = dx < 0 ? -dx : dx;
    uz = dz < 0 ? -dz : dz;
    if (ux <= rad && uz <= rad) begin
      dsq = ux * ux + uz * uz;
      if (dsq < rad * rad) begin
        d = longint'(root_floor(dsq));
        if (d * 10000 > (64'sd1 << FRAC_BITS)) begin
          gap = rad - d;
          r.x = 32'(sat32(px + (dx * gap) / d));
          r.z = 32'(sat32(pz + (dz * gap) / d));
          pushed_cnt++;
        end
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_PLAYER_X: centre_x = val;
      REG_PLAYER_Z: centre_z = val;
      REG_PUSH_RADIUS: radius = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every word has come back, then let the pipeline drain.
  task automatic settle();
    in_valid <= 0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send(particle_t p, bit has_exp, particle_t exp);
    particle_t pred;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pred = collide(p);
    if (has_exp && pred != exp) begin
      $error("directed row disagrees with predictor for x=%0d y=%0d", p.x, p.y);
      errors++;
    end
    in_valid <= 1;
    pos_x <= p.x;
    pos_y <= p.y;
    pos_z <= p.z;
    vel_y <= p.vy;
    last_in <= p.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    corrected_q.push_back(has_exp ? exp : pred);
    words_in++;
  endtask

  function automatic logic signed [31:0] rnd_coord(logic signed [31:0] c, logic [30:0] r);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return c + $signed($urandom_range(0, 2 * int'(r[29:0]) + 16)) - $signed(int'(r[29:0]));
      2: return c + $signed($urandom_range(0, 16)) - 8;
      default: return c + $signed($urandom_range(0, 2 * int'(r[29:0]))) - $signed(int'(r[29:0]));
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t p;
    p.x = rnd_coord(centre_x, radius);
    p.z = rnd_coord(centre_z, radius);
    p.y = $urandom;
    p.vy = $urandom;
    p.last = $urandom_range(0, 1);
    return p;
  endfunction

  function automatic particle_t mk(int x, int y, int z, int vy, bit last);
    particle_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.vy = vy;
    p.last = last;
    return p;
  endfunction

  // Receiver: random stalls, plus one long hold-off to back up the pipeline.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (!long_hold && words_in > 300) begin
        long_hold = 1;
        out_ready <= 0;
        repeat (200) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Check each returned word against the oldest expectation.
  always @(posedge clk) begin
    particle_t e;
    if (!rst && out_valid && out_ready) begin
      if (corrected_q.size() == 0) begin
        $error("unexpected word x=%0d", new_x);
        errors++;
      end else begin
        e = corrected_q.pop_front();
        words_out++;
        if (new_x !== e.x) begin $error("new_x exp %0d got %0d", e.x, new_x); errors++; end
        if (new_y !== e.y) begin $error("new_y exp %0d got %0d", e.y, new_y); errors++; end
        if (new_z !== e.z) begin $error("new_z exp %0d got %0d", e.z, new_z); errors++; end
        if (new_vy !== e.vy) begin
          $error("new_vy exp %0d got %0d", e.vy, new_vy);
          errors++;
        end
        if (last_out !== e.last) begin
          $error("last_out exp %0d got %0d", e.last, last_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
      $display("watchdog expired with %0d words outstanding", corrected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    particle_t nil;
    logic [31:0] cx[4], cz[4], cr[4];
    nil = mk(0, 0, 0, 0, 0);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Zero radius after reset: only the floor can act.
    rows.push_back('{mk(5, 7, 9, 3, 0), 1, mk(5, 7, 9, 3, 0)});
    rows.push_back('{mk(0, -1, 0, 100, 1), 1, mk(0, 0, 0, -50, 1)});
    rows.push_back('{mk(-2147483648, -2147483648, 2147483647, -2147483648, 1), 1,
                     mk(-2147483648, 0, 2147483647, 1073741824, 1)});
    rows.push_back('{mk(2147483647, 2147483647, -2147483648, 2147483647, 0), 1,
                     mk(2147483647, 2147483647, -2147483648, 2147483647, 0)});
    rows.push_back('{mk(1, -5, 1, -7, 0), 1, mk(1, 0, 1, 3, 0)});
    rows.push_back('{mk(0, 0, 0, -1, 1), 1, mk(0, 0, 0, -1, 1)});
    foreach (rows[i]) send(rows[i].stim, rows[i].has_exp, rows[i].exp);
    settle();

    // Unit radius at origin: axis, threshold, inside, on the wall, large offsets.
    write_reg(REG_PUSH_RADIUS, 32'h0001_0000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    rows.delete();
    rows.push_back('{mk(0, 0, 0, 0, 0), 1, mk(0, 0, 0, 0, 0)});
    rows.push_back('{mk(6, 1, 0, 0, 0), 1, mk(6, 1, 0, 0, 0)});
    rows.push_back('{mk(7, 1, 0, 0, 0), 0, nil});
    rows.push_back('{mk(8, 1, 0, 0, 1), 0, nil});
    rows.push_back('{mk(32768, -3, 0, 9, 0), 1, mk(65536, 0, 0, -4, 0)});
    rows.push_back('{mk(0, 2, -32768, 0, 0), 1, mk(0, 2, -65536, 0, 0)});
    rows.push_back('{mk(65536, 0, 0, 0, 0), 1, mk(65536, 0, 0, 0, 0)});
    rows.push_back('{mk(30000, 0, 30000, 0, 1), 0, nil});
    rows.push_back('{mk(-2147483648, 0, 0, 0, 0), 1, mk(-2147483648, 0, 0, 0, 0)});
    foreach (rows[i]) send(rows[i].stim, rows[i].has_exp, rows[i].exp);
    settle();

    // Huge radius near the corners: saturation of the push.
    write_reg(REG_PLAYER_X, 32'h7FFF_0000);
    write_reg(REG_PLAYER_Z, 32'h8001_0000);
    write_reg(REG_PUSH_RADIUS, 32'hFFFF_FFFF);
    send(mk(32'h7FFF_FF00, 5, 32'h8000_0100, 1, 0), 0, nil);
    send(mk(32'h7FFE_0000, 5, 32'h8002_0000, 1, 0), 0, nil);
    send(mk(32'h7FFF_0008, -5, 32'h8001_0000, -2147483648, 1), 0, nil);
    settle();

    // Random phases across several register settings.
    cx = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    cz = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    cr = '{32'h0000_0400, 32'h7FFF_FFFF, 32'h0003_0000, 32'h0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_reg(REG_PLAYER_X, cx[ph]);
        write_reg(REG_PLAYER_Z, cz[ph]);
        write_reg(REG_PUSH_RADIUS, cr[ph]);
      end else begin
        write_reg(REG_PLAYER_X, $urandom);
        write_reg(REG_PLAYER_Z, $urandom);
        write_reg(REG_PUSH_RADIUS, $urandom_range(0, 32'h0010_0000));
      end
      for (int n = 0; n < 150; n++) begin
        // pause once until the pipeline is empty
        if (ph == 2 && n == 75) begin
          in_valid <= 0;
          while (corrected_q.size() != 0) @(posedge clk);
        end
        send(rnd_particle(), 0, nil);
      end
      settle();
    end

    stim_done = 1;
    $display("%0d words sent, %0d returned; %0d pushed out, %0d floor bounces",
             words_in, words_out, pushed_cnt, bounce_cnt);
    if (errors == 0 && corrected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
